[rtl/ccbb_pkg.sv]
package ccbb_pkg;

  localparam int unsigned NumCodes  = 12;
  localparam int unsigned MaxWidth  = 1024;
  localparam int unsigned MaxHeight = 1024;
  localparam logic [7:0]  LevelLow  = 8'd64;
  localparam logic [7:0]  LevelHigh = 8'd192;

  localparam logic [8:0] ClassCode [NumCodes] = '{
    9'h004, 9'h014, 9'h024, 9'h022, 9'h020, 9'h0A0,
    9'h120, 9'h110, 9'h100, 9'h102, 9'h104, 9'h084
  };

  typedef struct packed {
    logic [10:0] y_end;
    logic [10:0] x_end;
    logic [9:0]  y_min;
    logic [9:0]  x_min;
  } box_t;

  typedef enum logic [1:0] {
    StStream = 2'b01,
    StReport = 2'b10
  } state_e;

  function automatic logic [1:0] level_bits(logic [7:0] v);
    logic [1:0] lv;
    if (v <= LevelLow) begin
      lv = 2'b00;
    end else if (v <= LevelHigh) begin
      lv = 2'b01;
    end else begin
      lv = 2'b10;
    end
    return lv;
  endfunction

  function automatic logic [8:0] color_code(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    return {level_bits(b), 1'b0, level_bits(g), 1'b0, level_bits(r), 1'b0};
  endfunction

endpackage

[rtl/ccbb_merge.sv]
module ccbb_merge (
  input  logic          seen_i,
  input  ccbb_pkg::box_t box_i,
  input  logic [9:0]    x_i,
  input  logic [9:0]    y_i,
  output ccbb_pkg::box_t box_o
);
  import ccbb_pkg::*;

  logic [10:0] x_end;
  logic [10:0] y_end;

  assign x_end = {1'b0, x_i} + 11'd1;
  assign y_end = {1'b0, y_i} + 11'd1;

  always_comb begin
    if (!seen_i) begin
      box_o.x_min = x_i;
      box_o.y_min = y_i;
      box_o.x_end = x_end;
      box_o.y_end = y_end;
    end else begin
      box_o.x_min = (x_i < box_i.x_min) ? x_i : box_i.x_min;
      box_o.y_min = (y_i < box_i.y_min) ? y_i : box_i.y_min;
      box_o.x_end = (x_end > box_i.x_end) ? x_end : box_i.x_end;
      box_o.y_end = (y_end > box_i.y_end) ? y_end : box_i.y_end;
    end
  end

endmodule

[rtl/color_class_bounding_boxes_unit.sv]
// Pixels: one beat per cycle while ready; two-stage read-modify-write on box memory.
// Report: once the last beat leaves stage 1 and the state turns to StReport, boxes
//   are registered out one per cycle while m_axis_tready holds; NUM_CLASSES in all.
// Input is held off from the last pixel beat until the final box is taken.
// Reset clears the seen flags and all control state; box memory contents are
//   not reset and are masked by the seen flags.
module color_class_bounding_boxes_unit #(
  parameter int NUM_CLASSES = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // pixel_x[9:0], pixel_y[19:10], red[27:20], green[35:28], blue[43:36], zero pad
  input  logic [47:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // class_id[3:0], found[4], box_x_min[14:5], box_y_min[24:15],
  // box_x_end[35:25], box_y_end[46:36], zero pad
  output logic [47:0] m_axis_tdata,
  output logic        m_axis_tlast
);
  import ccbb_pkg::*;

  localparam int IdxW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

  box_t mem [NUM_CLASSES];

  logic [9:0]  in_x, in_y;
  logic [8:0]  in_code;
  logic        in_hit;
  logic [IdxW-1:0] in_idx;
  logic        in_accept;

  logic        s1_valid_q;
  logic        s1_hit_q, s1_last_q;
  logic [IdxW-1:0] s1_idx_q;
  logic [9:0]  s1_x_q, s1_y_q;

  box_t        rd_q;
  logic        rd_en;
  logic [IdxW-1:0] rd_addr;

  logic        fwd_valid_q;
  logic [IdxW-1:0] fwd_idx_q;
  box_t        fwd_box_q;

  box_t        base_box, new_box;
  logic        wr_en;

  logic [NUM_CLASSES-1:0] seen_q;

  state_e      state_q;
  logic [IdxW-1:0] cnt_q;
  logic        rpt_load;

  logic        out_valid_q, out_seen_q, out_last_q;
  logic [IdxW-1:0] out_cls_q;

  assign in_x    = s_axis_tdata[9:0];
  assign in_y    = s_axis_tdata[19:10];
  assign in_code = color_code(s_axis_tdata[27:20], s_axis_tdata[35:28], s_axis_tdata[43:36]);

  always_comb begin
    in_hit = 1'b0;
    in_idx = '0;
    for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
      if (in_code == ClassCode[i]) begin
        in_hit = 1'b1;
        in_idx = IdxW'(i);
      end
    end
    if (!(32'(in_x) < MaxWidth) || !(32'(in_y) < MaxHeight)) begin
      in_hit = 1'b0;
    end
  end

  assign s_axis_tready = (state_q == StStream) && !(s1_valid_q && s1_last_q) && !out_valid_q;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  assign rpt_load = (state_q == StReport) && (!out_valid_q || m_axis_tready);
  assign rd_en    = in_accept || rpt_load;
  assign rd_addr  = (state_q == StReport) ? cnt_q : in_idx;

  assign base_box = (fwd_valid_q && fwd_idx_q == s1_idx_q) ? fwd_box_q : rd_q;
  assign wr_en    = s1_valid_q && s1_hit_q;

  ccbb_merge u_merge (
    .seen_i (seen_q[s1_idx_q]),
    .box_i  (base_box),
    .x_i    (s1_x_q),
    .y_i    (s1_y_q),
    .box_o  (new_box)
  );

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[s1_idx_q] <= new_box;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_hit_q  <= in_hit;
      s1_last_q <= s_axis_tlast;
      s1_idx_q  <= in_idx;
      s1_x_q    <= in_x;
      s1_y_q    <= in_y;
    end
    fwd_idx_q <= s1_idx_q;
    fwd_box_q <= new_box;
    if (rpt_load) begin
      out_cls_q  <= cnt_q;
      out_seen_q <= seen_q[cnt_q];
      out_last_q <= (cnt_q == IdxW'(NUM_CLASSES - 1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
      seen_q      <= '0;
      state_q     <= StStream;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= in_accept;
      fwd_valid_q <= wr_en;
      if (wr_en) begin
        seen_q[s1_idx_q] <= 1'b1;
      end
      unique case (state_q)
        StStream: begin
          if (out_valid_q && m_axis_tready) begin
            out_valid_q <= 1'b0;
          end
          if (s1_valid_q && s1_last_q) begin
            state_q <= StReport;
            cnt_q   <= '0;
          end
        end
        StReport: begin
          if (rpt_load) begin
            out_valid_q <= 1'b1;
            if (cnt_q == IdxW'(NUM_CLASSES - 1)) begin
              state_q <= StStream;
              cnt_q   <= '0;
              seen_q  <= '0;
            end else begin
              cnt_q <= cnt_q + IdxW'(1);
            end
          end
        end
        default: begin
          state_q <= StStream;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {1'b0,
                          out_seen_q ? rd_q.y_end : 11'd0,
                          out_seen_q ? rd_q.x_end : 11'd0,
                          out_seen_q ? rd_q.y_min : 10'd0,
                          out_seen_q ? rd_q.x_min : 10'd0,
                          out_seen_q,
                          4'(out_cls_q)};

endmodule

[rtl/ccbb_checker.sv]
module ccbb_checker #(
  parameter int NUM_CLASSES = 12
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // hold a stalled output beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output beat changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("pixel input open during report");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[4] |-> m_axis_tdata[46:5] == 42'd0)
    else $error("box of a class not found is not zero");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[4] |->
      ({1'b0, m_axis_tdata[14:5]} < m_axis_tdata[35:25]) &&
      ({1'b0, m_axis_tdata[24:15]} < m_axis_tdata[46:36]) &&
      (m_axis_tlast == (m_axis_tdata[3:0] == 4'(NUM_CLASSES - 1))))
    else $error("box bounds or last mark inconsistent");

endmodule

bind color_class_bounding_boxes_unit ccbb_checker #(.NUM_CLASSES(NUM_CLASSES)) u_ccbb_checker (.*);

[tb/tb_color_class_bounding_boxes_unit.sv]
module tb_color_class_bounding_boxes_unit;
  import ccbb_pkg::*;

  typedef struct {
    bit [3:0]  class_id;
    bit        found;
    bit [9:0]  x_min;
    bit [9:0]  y_min;
    bit [10:0] x_end;
    bit [10:0] y_end;
    bit        last_box;
  } box_rec_t;

  class class_box_tracker;
    bit [NumCodes-1:0] seen;
    bit [9:0]          lo_x [NumCodes];
    bit [9:0]          lo_y [NumCodes];
    bit [10:0]         hi_x [NumCodes];
    bit [10:0]         hi_y [NumCodes];
    box_rec_t          pending_boxes [$];
    int                errors;

    function void clear();
      seen = '0;
      for (int i = 0; i < NumCodes; i++) begin
        lo_x[i] = '0;
        lo_y[i] = '0;
        hi_x[i] = '0;
        hi_y[i] = '0;
      end
    endfunction

    function bit [1:0] band_of(bit [7:0] v);
      if (v <= 8'd64) return 2'b00;
      if (v <= 8'd192) return 2'b01;
      return 2'b10;
    endfunction

    function void take_pixel(bit [9:0] x, bit [9:0] y, bit [7:0] r, bit [7:0] g,
                             bit [7:0] b, bit last);
      bit [8:0]  code;
      bit [10:0] xe;
      bit [10:0] ye;
      box_rec_t  rec;
      code = (9'(band_of(r)) << 1) | (9'(band_of(g)) << 4) | (9'(band_of(b)) << 7);
      xe = {1'b0, x} + 11'd1;
      ye = {1'b0, y} + 11'd1;
      if (x < MaxWidth && y < MaxHeight) begin
        for (int i = 0; i < NumCodes; i++) begin
          if (ClassCode[i] == code) begin
            if (!seen[i]) begin
              seen[i] = 1'b1;
              lo_x[i] = x;
              lo_y[i] = y;
              hi_x[i] = xe;
              hi_y[i] = ye;
            end else begin
              if (x < lo_x[i]) lo_x[i] = x;
              if (y < lo_y[i]) lo_y[i] = y;
              if (xe > hi_x[i]) hi_x[i] = xe;
              if (ye > hi_y[i]) hi_y[i] = ye;
            end
            break;
          end
        end
      end
      if (last) begin
        for (int i = 0; i < NumCodes; i++) begin
          rec.class_id = 4'(i);
          rec.found    = seen[i];
          rec.x_min    = seen[i] ? lo_x[i] : '0;
          rec.y_min    = seen[i] ? lo_y[i] : '0;
          rec.x_end    = seen[i] ? hi_x[i] : '0;
          rec.y_end    = seen[i] ? hi_y[i] : '0;
          rec.last_box = (i == NumCodes - 1);
          pending_boxes.push_back(rec);
        end
        clear();
      end
    endfunction

    function void check_box(bit [47:0] d, bit tl);
      box_rec_t e;
      if (pending_boxes.size() == 0) begin
        $error("unexpected box beat: class_id %0d", d[3:0]);
        errors++;
        return;
      end
      e = pending_boxes.pop_front();
      if (d[3:0] != e.class_id) begin
        $error("class_id: expected %0d, got %0d", e.class_id, d[3:0]);
        errors++;
      end
      if (d[4] != e.found) begin
        $error("found: expected %0d, got %0d", e.found, d[4]);
        errors++;
      end
      if (d[14:5] != e.x_min) begin
        $error("box_x_min: expected %0d, got %0d", e.x_min, d[14:5]);
        errors++;
      end
      if (d[24:15] != e.y_min) begin
        $error("box_y_min: expected %0d, got %0d", e.y_min, d[24:15]);
        errors++;
      end
      if (d[35:25] != e.x_end) begin
        $error("box_x_end: expected %0d, got %0d", e.x_end, d[35:25]);
        errors++;
      end
      if (d[46:36] != e.y_end) begin
        $error("box_y_end: expected %0d, got %0d", e.y_end, d[46:36]);
        errors++;
      end
      if (tl != e.last_box) begin
        $error("last_box: expected %0d, got %0d", e.last_box, tl);
        errors++;
      end
    endfunction

    function int pending();
      return pending_boxes.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tlast;

  class_box_tracker tracker = new();
  int burst_left = 0;
  int pixels_sent = 0;
  int ready_mode = 0;
  int ready_cnt = 0;

  color_class_bounding_boxes_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #400000;
    $display("Regression FAIL");
    $finish;
  end

  // receiver: check taken boxes and switch among random stall patterns
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      tracker.check_box(m_axis_tdata, m_axis_tlast);
    end
    ready_cnt <= ready_cnt + 1;
    if (ready_cnt % 64 == 63) begin
      ready_mode <= $urandom_range(0, 3);
    end
    case (ready_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 99) < 60);
      2: m_axis_tready <= (ready_cnt % 4 == 0);
      default: m_axis_tready <= ((ready_cnt / 8) % 2 == 0);
    endcase
  end

  function automatic bit [7:0] channel_value(bit [1:0] lvl, int sel);
    case (lvl)
      2'b00: return (sel == 0) ? 8'd0 : (sel == 1) ? 8'd64 : 8'($urandom_range(0, 64));
      2'b01: return (sel == 0) ? 8'd65 : (sel == 1) ? 8'd192 : 8'($urandom_range(65, 192));
      default: return (sel == 0) ? 8'd193 : (sel == 1) ? 8'd255 : 8'($urandom_range(193, 255));
    endcase
  endfunction

  task automatic send_pixel(input bit [9:0] x, input bit [9:0] y, input bit [7:0] r,
                            input bit [7:0] g, input bit [7:0] b, input bit last);
    int gap;
    s_axis_tdata  <= {4'b0, b, g, r, y, x};
    s_axis_tlast  <= last;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.take_pixel(x, y, r, g, b, last);
    pixels_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 10);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_class_pixel(input int k, input bit [9:0] x, input bit [9:0] y,
                                  input int sel, input bit last);
    bit [8:0] c;
    c = ClassCode[k];
    send_pixel(x, y, channel_value(c[2:1], sel), channel_value(c[5:4], sel),
               channel_value(c[8:7], sel), last);
  endtask

  // drop valid and hold until every expected box has been taken
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (tracker.pending() != 0);
  endtask

  initial begin
    int len;
    int k;
    int frames;
    bit [9:0] x;
    bit [9:0] y;
    frames = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty image
    send_pixel(10'd5, 10'd7, 8'd0, 8'd0, 8'd0, 1'b1);
    for (int i = 0; i < NumCodes; i++) begin
      send_class_pixel(i, (i % 2) ? 10'd1023 : 10'd0, (i % 2) ? 10'd0 : 10'd1023,
                       i % 2, 1'b0);
    end
    send_class_pixel(0, 10'd1023, 10'd0, 2, 1'b0);
    send_class_pixel(1, 10'd0, 10'd1023, 2, 1'b0);
    send_pixel(10'd300, 10'd400, 8'd255, 8'd255, 8'd255, 1'b0);
    send_pixel(10'd301, 10'd401, 8'd128, 8'd128, 8'd128, 1'b0);
    send_class_pixel(5, 10'd512, 10'd300, 2, 1'b1);
    // the class is seen only on the last pixel
    send_pixel(10'd1, 10'd2, 8'd100, 8'd100, 8'd100, 1'b0);
    send_class_pixel(3, 10'd700, 10'd33, 2, 1'b1);
    drain();

    while (pixels_sent < 240) begin
      if (frames == 6) drain();
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
      for (int j = 0; j < len; j++) begin
        x = 10'($urandom_range(0, 1023));
        y = 10'($urandom_range(0, 1023));
        if ($urandom_range(0, 19) == 0) x = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
        if ($urandom_range(0, 19) == 0) y = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
        if ($urandom_range(0, 99) < 85) begin
          k = $urandom_range(0, NumCodes - 1);
          send_class_pixel(k, x, y, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : 2,
                           j == len - 1);
        end else begin
          send_pixel(x, y, 8'($urandom), 8'($urandom), 8'($urandom), j == len - 1);
        end
      end
      frames++;
    end

    s_axis_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
